// File: rtl/rast_pkg.sv
// rast_pkg: shared types and constants for the range add / range sum tree.
// Used by rast_core and range_add_range_sum_tree; no dependencies.
package rast_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int COUNT_W          = 11;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [COUNT_W-1:0]       left_index;
    logic [COUNT_W-1:0]       right_index;
    logic signed [31:0]       add_value;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] range_sum;
    logic               range_error;
  } out_word_t;

endpackage

// File: rtl/rast_ram.sv
// rast_ram: single write port, single read port RAM, registered read data.
// No dependencies.
module rast_ram #(
  parameter int Depth = 1024,
  parameter int Width = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/rast_core.sv
// rast_core: sequencer for two Fenwick arrays (range add, range sum).
// Depends on rast_pkg; drives the two rast_ram instances in the top level.
module rast_core #(
  parameter int MaxElements = rast_pkg::MAX_ELEMENTS_DEF,
  localparam int AW = (MaxElements > 1) ? $clog2(MaxElements) : 1,
  localparam int IW = $clog2(MaxElements + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  rast_pkg::in_word_t    in_word,
  output logic                  out_valid,
  output rast_pkg::out_word_t   out_word,
  input  logic                  cfg_we,
  input  logic [rast_pkg::COUNT_W-1:0] cfg_data,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [AW-1:0]         mem_raddr,
  output logic [63:0]           mem_wdata1,
  output logic [63:0]           mem_wdata2,
  input  logic [63:0]           mem_rdata1,
  input  logic [63:0]           mem_rdata2
);

  localparam int XW = IW + 1;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_PREP = 8'b0000_0100,
    S_URD  = 8'b0000_1000,
    S_UWR  = 8'b0001_0000,
    S_QRD  = 8'b0010_0000,
    S_QACC = 8'b0100_0000,
    S_QFIN = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [rast_pkg::COUNT_W-1:0] count_r;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [XW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] l_r, l_nxt, r_r, r_nxt, pi_r, pi_nxt;
  logic          pass_r, pass_nxt;
  logic signed [31:0] v_r, v_nxt;
  logic [63:0] d1_r, d1_nxt, d2_r, d2_nxt, pr_r, pr_nxt;
  logic [63:0] s1_r, s1_nxt, s2_r, s2_nxt, acc_r, acc_nxt;
  logic [63:0] mlo_r, mlo_nxt, mhi_r, mhi_nxt;
  logic        ov_r, ov_nxt;
  rast_pkg::out_word_t ow_r, ow_nxt;
  logic        mul_r, mul_nxt;

  logic [31:0] eff_count;
  logic        range_ok;
  logic [XW-1:0] lowbit, idx_up, idx_dn;
  logic signed [32+IW:0] prod_l, prod_r;
  logic [63:0] prefix;

  always_comb begin
    eff_count = (32'(count_r) > 32'(MaxElements)) ? 32'(MaxElements) : 32'(count_r);
    range_ok = (in_word.left_index != '0) && (in_word.left_index <= in_word.right_index)
               && (32'(in_word.right_index) <= eff_count);
    lowbit = idx_r & (~idx_r + XW'(1));
    idx_up = idx_r + lowbit;
    idx_dn = idx_r & (idx_r - XW'(1));
    prod_l = v_r * $signed({1'b0, l_r - IW'(1)});
    prod_r = v_r * $signed({1'b0, r_r});
    prefix = mlo_r + {mhi_r[31:0], 32'b0} - s2_r;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    idx_nxt = idx_r;
    l_nxt = l_r;
    r_nxt = r_r;
    pi_nxt = pi_r;
    pass_nxt = pass_r;
    v_nxt = v_r;
    d1_nxt = d1_r;
    d2_nxt = d2_r;
    pr_nxt = pr_r;
    s1_nxt = s1_r;
    s2_nxt = s2_r;
    acc_nxt = acc_r;
    mlo_nxt = mlo_r;
    mhi_nxt = mhi_r;
    ov_nxt = 1'b0;
    ow_nxt = ow_r;
    mul_nxt = 1'b0;
    mem_we = 1'b0;
    mem_waddr = idx_r[AW-1:0] - AW'(1);
    mem_raddr = idx_r[AW-1:0] - AW'(1);
    mem_wdata1 = mem_rdata1 + d1_r;
    mem_wdata2 = mem_rdata2 + d2_r;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_r;
        mem_wdata1 = '0;
        mem_wdata2 = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MaxElements - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          l_nxt = IW'(in_word.left_index);
          r_nxt = IW'(in_word.right_index);
          v_nxt = in_word.add_value;
          pass_nxt = 1'b0;
          if (in_word.mode == rast_pkg::MODE_QUERY) begin
            if (range_ok) begin
              idx_nxt = XW'(in_word.right_index);
              pi_nxt = IW'(in_word.right_index);
              s1_nxt = '0;
              s2_nxt = '0;
              state_nxt = S_QRD;
            end else begin
              ov_nxt = 1'b1;
              ow_nxt.range_sum = '0;
              ow_nxt.range_error = 1'b1;
            end
          end else if (range_ok) begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        d1_nxt = 64'(v_r);
        d2_nxt = 64'(prod_l);
        pr_nxt = 64'(prod_r);
        idx_nxt = XW'(l_r);
        state_nxt = S_URD;
      end
      S_URD: begin
        state_nxt = S_UWR;
      end
      S_UWR: begin
        mem_we = 1'b1;
        if (32'(idx_up) <= 32'(MaxElements)) begin
          idx_nxt = idx_up;
          state_nxt = S_URD;
        end else if (!pass_r && (32'(r_r) < 32'(MaxElements))) begin
          idx_nxt = XW'(r_r) + XW'(1);
          d1_nxt = -d1_r;
          d2_nxt = -pr_r;
          pass_nxt = 1'b1;
          state_nxt = S_URD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_QRD: begin
        if (idx_r == '0) begin
          mlo_nxt = 64'(s1_r[31:0]) * 64'(pi_r);
          mhi_nxt = 64'(s1_r[63:32] * 32'(pi_r));
          mul_nxt = 1'b1;
          state_nxt = S_QFIN;
        end else begin
          state_nxt = S_QACC;
        end
      end
      S_QACC: begin
        s1_nxt = s1_r + mem_rdata1;
        s2_nxt = s2_r + mem_rdata2;
        idx_nxt = idx_dn;
        state_nxt = S_QRD;
      end
      S_QFIN: begin
        if (!pass_r) begin
          acc_nxt = prefix;
          pass_nxt = 1'b1;
          pi_nxt = l_r - IW'(1);
          idx_nxt = XW'(l_r - IW'(1));
          s1_nxt = '0;
          s2_nxt = '0;
          state_nxt = S_QRD;
        end else begin
          ov_nxt = 1'b1;
          ow_nxt.range_sum = acc_r - prefix;
          ow_nxt.range_error = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      count_r <= rast_pkg::COUNT_RESET;
      ov_r <= 1'b0;
      mul_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      ov_r <= ov_nxt;
      mul_r <= mul_nxt;
      if (cfg_we) begin
        count_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    l_r <= l_nxt;
    r_r <= r_nxt;
    pi_r <= pi_nxt;
    pass_r <= pass_nxt;
    v_r <= v_nxt;
    d1_r <= d1_nxt;
    d2_r <= d2_nxt;
    pr_r <= pr_nxt;
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    acc_r <= acc_nxt;
    mlo_r <= mlo_nxt;
    mhi_r <= mhi_nxt;
    ow_r <= ow_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_word = ow_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE)) else $error("result outside idle");
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_UWR || state_r == S_CLR)) else $error("stray write");
  a_add_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_word.mode == rast_pkg::MODE_ADD) |=> !out_valid)
    else $error("add produced result");
  a_fin_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QFIN) |-> mul_r) else $error("finish without products");

endmodule

// File: rtl/range_add_range_sum_tree.sv
// Range add / range sum over a one-based array of MaxElements signed elements,
// kept as two Fenwick arrays (per-element adds and index-weighted adds) in two
// RAMs with one read and one write port each. After reset a clearing pass
// zeroes every RAM word with busy high. A range add runs a setup state, then
// walks the update path from left_index and, unless right_index is MaxElements,
// the path from right_index+1, reading each node from RAM and then writing it
// back. A query walks two prefix paths, reading and adding up each node, then
// forming the index products and a finishing step per path. A rejected item
// leaves busy low; a rejected query answers in the next cycle with range_error
// set. Results appear for one cycle on out_valid and cannot be held.
// Depends on rast_pkg, rast_ram, rast_core.
module range_add_range_sum_tree #(
  parameter int MaxElements = rast_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rast_pkg::in_word_t            in_word,
  output logic                          out_valid,
  output rast_pkg::out_word_t           out_word,
  input  logic                          cfg_we,
  input  logic [rast_pkg::COUNT_W-1:0]  cfg_data
);

  localparam int AW = (MaxElements > 1) ? $clog2(MaxElements) : 1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata1, mem_wdata2, mem_rdata1, mem_rdata2;

  rast_core #(.MaxElements(MaxElements)) u_core (
    .clk, .rst_n, .start, .busy, .in_word, .out_valid, .out_word,
    .cfg_we, .cfg_data,
    .mem_we, .mem_waddr, .mem_raddr, .mem_wdata1, .mem_wdata2,
    .mem_rdata1, .mem_rdata2
  );

  rast_ram #(.Depth(MaxElements), .Width(64)) u_ram_lin (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata1),
    .raddr(mem_raddr), .rdata(mem_rdata1)
  );

  rast_ram #(.Depth(MaxElements), .Width(64)) u_ram_wgt (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata2),
    .raddr(mem_raddr), .rdata(mem_rdata2)
  );

endmodule
